// ----- design/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_ID_BITS   = 16;
    localparam int DEF_PRIO_BITS = 8;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// ----- design/spq_req_if.sv -----
`default_nettype none

interface spq_req_if #(
    parameter int ID_W   = spq_pkg::DEF_ID_BITS,
    parameter int PRIO_W = spq_pkg::DEF_PRIO_BITS
);
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::CMD_W-1:0]   cmd;
    logic [ID_W-1:0]             item_id;
    logic [PRIO_W-1:0]           item_priority;

    modport source (output valid, output cmd, output item_id, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_id, input item_priority,
                    output ready);
endinterface

`default_nettype wire

// ----- design/spq_rsp_if.sv -----
`default_nettype none

interface spq_rsp_if #(
    parameter int ID_W   = spq_pkg::DEF_ID_BITS,
    parameter int PRIO_W = spq_pkg::DEF_PRIO_BITS,
    parameter int CNT_W  = $clog2(spq_pkg::DEF_CAPACITY + 1)
);
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic                          hit;
    logic [PRIO_W-1:0]             found_priority;
    logic                          head_valid;
    logic [ID_W-1:0]               head_id;
    logic [PRIO_W-1:0]             head_priority;
    logic [CNT_W-1:0]              fill_count;

    modport source (output valid, output status, output hit, output found_priority,
                    output head_valid, output head_id, output head_priority,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input hit, input found_priority,
                    input head_valid, input head_id, input head_priority,
                    input fill_count, output ready);
endinterface

`default_nettype wire

// ----- design/spq_ram.sv -----
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = spq_pkg::DEF_CAPACITY
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Sequence: an accepted command that only reports the head passes S_HEAD_RD, S_HEAD_WAIT
// (skipped when the queue ends empty) and S_FINISH; each entry scanned adds S_SCAN_RD and
// S_SCAN_CHK, each entry moved adds S_SHIFT_RD and S_SHIFT_WR, and a store adds S_PUT.
// Throughput: one command at a time; the slot RAM has one read and one write port
// and every scan or move step waits on its registered read.
// Reset: rst_n (asynchronous, active low) empties the queue; slot RAM is not cleared.
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY  = spq_pkg::DEF_CAPACITY,
    parameter int ID_BITS   = spq_pkg::DEF_ID_BITS,
    parameter int PRIO_BITS = spq_pkg::DEF_PRIO_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    request,
    spq_rsp_if.source  response
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = ID_BITS + PRIO_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [IDX_W-1:0]              ptr_reg;
    logic [IDX_W-1:0]              pos_reg;
    logic                          up_reg;
    logic [spq_pkg::CMD_W-1:0]     op_reg;
    logic [ID_BITS-1:0]            id_reg;
    logic [PRIO_BITS-1:0]          prio_reg;
    logic [spq_pkg::STATUS_W-1:0]  status_reg;
    logic                          hit_reg;
    logic [PRIO_BITS-1:0]          fprio_reg;
    logic                          hvalid_reg;
    logic [ID_BITS-1:0]            hid_reg;
    logic [PRIO_BITS-1:0]          hprio_reg;

    logic                          out_valid_reg;
    logic [spq_pkg::STATUS_W-1:0]  out_status_reg;
    logic                          out_hit_reg;
    logic [PRIO_BITS-1:0]          out_fprio_reg;
    logic                          out_hvalid_reg;
    logic [ID_BITS-1:0]            out_hid_reg;
    logic [PRIO_BITS-1:0]          out_hprio_reg;
    logic [CNT_W-1:0]              out_count_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    logic [ID_BITS-1:0]    rd_id;
    logic [PRIO_BITS-1:0]  rd_prio;
    logic [CNT_W-1:0]      ptr_inc;
    logic                  full;
    logic                  take;

    assign rd_id   = ram_rdata[ENT_W-1:PRIO_BITS];
    assign rd_prio = ram_rdata[PRIO_BITS-1:0];
    assign ptr_inc = CNT_W'(ptr_reg) + CNT_W'(1);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    assign request.ready = (state_reg == S_IDLE);
    assign take          = request.valid && request.ready;

    // Slot RAM control: up-shift copies toward the tail, down-shift toward the head
    always_comb
    begin
        ram_we    = (state_reg == S_SHIFT_WR) || (state_reg == S_PUT);
        ram_raddr = (state_reg == S_HEAD_RD) ? '0 : ptr_reg;
        if (state_reg == S_PUT)
        begin
            ram_waddr = pos_reg;
            ram_wdata = {id_reg, prio_reg};
        end
        else
        begin
            ram_waddr = up_reg ? (ptr_reg + IDX_W'(1)) : (ptr_reg - IDX_W'(1));
            ram_wdata = ram_rdata;
        end
    end

    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pos_reg        <= '0;
            up_reg         <= 1'b0;
            op_reg         <= '0;
            id_reg         <= '0;
            prio_reg       <= '0;
            status_reg     <= spq_pkg::ST_DONE;
            hit_reg        <= 1'b0;
            fprio_reg      <= '0;
            hvalid_reg     <= 1'b0;
            hid_reg        <= '0;
            hprio_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= spq_pkg::ST_DONE;
            out_hit_reg    <= 1'b0;
            out_fprio_reg  <= '0;
            out_hvalid_reg <= 1'b0;
            out_hid_reg    <= '0;
            out_hprio_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && response.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        op_reg    <= request.cmd;
                        id_reg    <= request.item_id;
                        prio_reg  <= request.item_priority;
                        fprio_reg <= '0;
                        up_reg    <= 1'b0;
                        hit_reg   <= (request.cmd == spq_pkg::CMD_POP) && (count_reg != '0);
                        ptr_reg   <= (request.cmd == spq_pkg::CMD_POP) ? IDX_W'(1) : '0;
                        case (request.cmd)
                            spq_pkg::CMD_APPEND:
                            begin
                                if (full)
                                begin
                                    status_reg <= spq_pkg::ST_FULL;
                                    state_reg  <= S_HEAD_RD;
                                end
                                else
                                begin
                                    status_reg <= spq_pkg::ST_DONE;
                                    pos_reg    <= count_reg[IDX_W-1:0];
                                    state_reg  <= S_PUT;
                                end
                            end
                            spq_pkg::CMD_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= spq_pkg::ST_FULL;
                                    state_reg  <= S_HEAD_RD;
                                end
                                else if (count_reg == '0)
                                begin
                                    status_reg <= spq_pkg::ST_DONE;
                                    pos_reg    <= '0;
                                    state_reg  <= S_PUT;
                                end
                                else
                                begin
                                    status_reg <= spq_pkg::ST_DONE;
                                    state_reg  <= S_SCAN_RD;
                                end
                            end
                            spq_pkg::CMD_REMOVE,
                            spq_pkg::CMD_FIND:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= spq_pkg::ST_EMPTY;
                                    state_reg  <= S_HEAD_RD;
                                end
                                else
                                begin
                                    status_reg <= spq_pkg::ST_DONE;
                                    state_reg  <= S_SCAN_RD;
                                end
                            end
                            spq_pkg::CMD_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= spq_pkg::ST_EMPTY;
                                    state_reg  <= S_HEAD_RD;
                                end
                                else
                                begin
                                    status_reg <= spq_pkg::ST_DONE;
                                    if (count_reg == CNT_W'(1))
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                        state_reg <= S_HEAD_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_SHIFT_RD;
                                    end
                                end
                            end
                            default:
                            begin
                                status_reg <= spq_pkg::ST_DONE;
                                state_reg  <= S_HEAD_RD;
                            end
                        endcase
                    end
                end

                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end

                S_SCAN_CHK:
                begin
                    if (op_reg == spq_pkg::CMD_INSERT)
                    begin
                        if (rd_prio < prio_reg)
                        begin
                            // open a gap at ptr: move tail entries up one slot
                            pos_reg   <= ptr_reg;
                            ptr_reg   <= IDX_W'(count_reg - CNT_W'(1));
                            up_reg    <= 1'b1;
                            state_reg <= S_SHIFT_RD;
                        end
                        else if (ptr_inc == count_reg)
                        begin
                            pos_reg   <= count_reg[IDX_W-1:0];
                            state_reg <= S_PUT;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + IDX_W'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else if (rd_id == id_reg)
                    begin
                        hit_reg <= 1'b1;
                        if (op_reg == spq_pkg::CMD_FIND)
                        begin
                            fprio_reg <= rd_prio;
                            state_reg <= S_HEAD_RD;
                        end
                        else if (ptr_inc == count_reg)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                            state_reg <= S_HEAD_RD;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + IDX_W'(1);
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    else if (ptr_inc == count_reg)
                    begin
                        status_reg <= spq_pkg::ST_NOTFOUND;
                        state_reg  <= S_HEAD_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + IDX_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end

                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end

                S_SHIFT_WR:
                begin
                    if (up_reg)
                    begin
                        if (ptr_reg == pos_reg)
                        begin
                            state_reg <= S_PUT;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg - IDX_W'(1);
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    else if (ptr_inc == count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_HEAD_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + IDX_W'(1);
                        state_reg <= S_SHIFT_RD;
                    end
                end

                S_PUT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_HEAD_RD;
                end

                S_HEAD_RD:
                begin
                    if (count_reg == '0)
                    begin
                        hvalid_reg <= 1'b0;
                        hid_reg    <= '0;
                        hprio_reg  <= '0;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_HEAD_WAIT;
                    end
                end

                S_HEAD_WAIT:
                begin
                    hvalid_reg <= 1'b1;
                    hid_reg    <= rd_id;
                    hprio_reg  <= rd_prio;
                    state_reg  <= S_FINISH;
                end

                S_FINISH:
                begin
                    // hold until the previous response word is gone
                    if (!out_valid_reg || response.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_hit_reg    <= hit_reg;
                        out_fprio_reg  <= fprio_reg;
                        out_hvalid_reg <= hvalid_reg;
                        out_hid_reg    <= hid_reg;
                        out_hprio_reg  <= hprio_reg;
                        out_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign response.valid          = out_valid_reg;
    assign response.status         = out_status_reg;
    assign response.hit            = out_hit_reg;
    assign response.found_priority = out_fprio_reg;
    assign response.head_valid     = out_hvalid_reg;
    assign response.head_id        = out_hid_reg;
    assign response.head_priority  = out_hprio_reg;
    assign response.fill_count     = out_count_reg;

endmodule

`default_nettype wire

// ----- design/spq_checker.sv -----
`default_nettype none

module spq_checker #(
    parameter int CAPACITY  = spq_pkg::DEF_CAPACITY,
    parameter int ID_BITS   = spq_pkg::DEF_ID_BITS,
    parameter int PRIO_BITS = spq_pkg::DEF_PRIO_BITS
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [spq_pkg::STATUS_W-1:0]         rsp_status,
    input wire logic                                 rsp_hit,
    input wire logic [PRIO_BITS-1:0]                 rsp_found_priority,
    input wire logic                                 rsp_head_valid,
    input wire logic [ID_BITS-1:0]                   rsp_head_id,
    input wire logic [$clog2(CAPACITY + 1)-1:0]      rsp_fill_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // a stalled response word holds its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_fill_count) && $stable(rsp_head_id))
        else $error("response word changed while stalled");

    a_head_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_head_valid == (rsp_fill_count != '0))
            && (rsp_fill_count <= CNT_W'(CAPACITY)))
        else $error("head_valid disagrees with fill_count");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == spq_pkg::ST_FULL)
            |-> !rsp_hit && (rsp_fill_count == CNT_W'(CAPACITY)))
        else $error("full rejection reported with room left or a hit");

    a_found_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_found_priority != '0)
            |-> rsp_hit && (rsp_status == spq_pkg::ST_DONE))
        else $error("found_priority set without a hit");

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY  (CAPACITY),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
) u_spq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (response.valid),
    .rsp_ready          (response.ready),
    .rsp_status         (response.status),
    .rsp_hit            (response.hit),
    .rsp_found_priority (response.found_priority),
    .rsp_head_valid     (response.head_valid),
    .rsp_head_id        (response.head_id),
    .rsp_fill_count     (response.fill_count)
);

`default_nettype wire
